// ----- hw/rtl/nearest_code_position_matcher_macros.svh -----
// assertion macros used by the matcher rtl
`ifndef NEAREST_CODE_POSITION_MATCHER_MACROS_SVH
`define NEAREST_CODE_POSITION_MATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define NCPM_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NCPM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// condition never seen
`define NCPM_ASSERT_NEVER(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error(msg);

`else

`define NCPM_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg)
`define NCPM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`define NCPM_ASSERT_NEVER(lbl, ck, rs, cond, msg)

`endif

`endif

// ----- hw/rtl/ncpm_pkg.sv -----
package ncpm_pkg;

  // default sizing
  localparam int MAX_CODES_DEF = 64;
  localparam int PIN_WIDTH_DEF = 25;

  // item field widths
  localparam int KIND_W          = 1;
  localparam int ENTRY_INDEX_W   = 6;
  localparam int ENTRY_CODE_W    = 25;
  localparam int PIN_SAMPLE_W    = 32;
  localparam int BEST_DISTANCE_W = 5;
  localparam int BEST_INDEX_W    = 6;
  localparam int NUM_CODES_W     = 7;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b1;

  // register reset and saturation values
  localparam logic [NUM_CODES_W-1:0]     NUM_CODES_RESET = 7'd50;
  localparam logic [BEST_DISTANCE_W-1:0] DIST_SAT        = 5'd31;

  // control part of a search token travelling down the cell row
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

endpackage

// ----- hw/rtl/ncpm_if.sv -----
// input item channel
interface ncpm_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [ncpm_pkg::KIND_W-1:0]          kind;
  logic [ncpm_pkg::ENTRY_INDEX_W-1:0]   entry_index;
  logic [ncpm_pkg::ENTRY_CODE_W-1:0]    entry_code;
  logic [ncpm_pkg::PIN_SAMPLE_W-1:0]    pin_sample;

  modport source (output valid, kind, entry_index, entry_code, pin_sample, input ready);
  modport sink (input valid, kind, entry_index, entry_code, pin_sample, output ready);
endinterface

// result item channel
interface ncpm_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [ncpm_pkg::BEST_DISTANCE_W-1:0] best_distance;
  logic [ncpm_pkg::BEST_INDEX_W-1:0]    best_index;

  modport source (output valid, best_distance, best_index, input ready);
  modport sink (input valid, best_distance, best_index, output ready);
endinterface

// ----- hw/rtl/nearest_code_position_matcher.sv -----
// channel    dir  payload                                          handshake
// items      in   kind, entry_index, entry_code, pin_sample        valid/ready
// results    out  best_distance, best_index                        valid/ready
// cfg        in   cfg_wdata (num_codes)                            cfg_we, no ready
//
// loads and unchanged samples do not start a search
// a changed sample walks the row of MAX_CODES cells, one cell per cycle, and
// ready stays low until its token has left the end of the row
// ready is also low while a finished result waits behind a full output register
// rst clears control and last sample and sets num_codes to 50; code table has no reset

`include "nearest_code_position_matcher_macros.svh"

module nearest_code_position_matcher #(
  parameter int MAX_CODES = ncpm_pkg::MAX_CODES_DEF,
  parameter int PIN_WIDTH = ncpm_pkg::PIN_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  ncpm_item_if.sink                        items,
  ncpm_result_if.source                    results,
  input  logic                             cfg_we,
  input  logic [ncpm_pkg::NUM_CODES_W-1:0] cfg_wdata
);

  localparam int DIST_W = $clog2(PIN_WIDTH + 1);
  localparam int IDX_W  = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
  localparam int CNT_W  = $clog2(MAX_CODES + 1);

  logic [ncpm_pkg::NUM_CODES_W-1:0] num_codes;
  logic [CNT_W-1:0]                 count_sat;
  logic [PIN_WIDTH-1:0]             last_sample;
  logic [PIN_WIDTH-1:0]             sample_m;
  logic [PIN_WIDTH-1:0]             code_m;
  logic                             accept;
  logic                             is_load;
  logic                             start;
  logic                             busy;

  ncpm_pkg::tok_ctl_t   tok_ctl    [0:MAX_CODES];
  logic [PIN_WIDTH-1:0] tok_sample [0:MAX_CODES];
  logic [DIST_W-1:0]    tok_dist   [0:MAX_CODES];
  logic [IDX_W-1:0]     tok_idx    [0:MAX_CODES];

  logic                                 exit_valid;
  logic [31:0]                          exit_dist32;
  logic [ncpm_pkg::BEST_DISTANCE_W-1:0] res_dist;
  logic [ncpm_pkg::BEST_INDEX_W-1:0]    res_idx;

  logic                                 out_valid;
  logic [ncpm_pkg::BEST_DISTANCE_W-1:0] out_dist;
  logic [ncpm_pkg::BEST_INDEX_W-1:0]    out_idx;
  logic                                 skid_valid;
  logic [ncpm_pkg::BEST_DISTANCE_W-1:0] skid_dist;
  logic [ncpm_pkg::BEST_INDEX_W-1:0]    skid_idx;
  logic                                 out_free;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_codes <= ncpm_pkg::NUM_CODES_RESET;
    end else if (cfg_we) begin
      num_codes <= cfg_wdata;
    end
  end

  // entry count clipped to the table size
  always_comb begin
    if (32'(num_codes) > MAX_CODES) begin
      count_sat = CNT_W'(MAX_CODES);
    end else begin
      count_sat = CNT_W'(num_codes);
    end
  end

  // input decode
  assign items.ready = !busy && !skid_valid;
  assign accept      = items.valid && items.ready;
  assign sample_m    = PIN_WIDTH'(items.pin_sample);
  assign code_m      = PIN_WIDTH'(items.entry_code);
  assign is_load     = accept && (items.kind == ncpm_pkg::KIND_LOAD);
  assign start       = accept && (items.kind == ncpm_pkg::KIND_SAMPLE) &&
                       (sample_m != last_sample);

  // last sample seen
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample <= '0;
    end else if (start) begin
      last_sample <= sample_m;
    end
  end

  // search in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (exit_valid) begin
      busy <= 1'b0;
    end
  end

  // token entering the first cell
  always_comb begin
    tok_ctl[0].valid = start;
    tok_ctl[0].found = 1'b0;
    tok_sample[0]    = sample_m;
    tok_dist[0]      = '0;
    tok_idx[0]       = '0;
  end

  // row of cells
  for (genvar i = 0; i < MAX_CODES; i++) begin : g_cell
    logic load_en;
    assign load_en = is_load && (32'(items.entry_index) == i);

    ncpm_cell #(
      .PIN_WIDTH (PIN_WIDTH),
      .DIST_W    (DIST_W),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .CELL_ID   (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load_en    (load_en),
      .load_code  (code_m),
      .count      (count_sat),
      .in_ctl     (tok_ctl[i]),
      .in_sample  (tok_sample[i]),
      .in_dist    (tok_dist[i]),
      .in_idx     (tok_idx[i]),
      .out_ctl    (tok_ctl[i+1]),
      .out_sample (tok_sample[i+1]),
      .out_dist   (tok_dist[i+1]),
      .out_idx    (tok_idx[i+1])
    );
  end

  // result formatting at the end of the row
  always_comb begin
    exit_valid  = tok_ctl[MAX_CODES].valid;
    exit_dist32 = 32'(tok_dist[MAX_CODES]);
    if (!tok_ctl[MAX_CODES].found || (exit_dist32 > 32'(ncpm_pkg::DIST_SAT))) begin
      res_dist = ncpm_pkg::DIST_SAT;
    end else begin
      res_dist = ncpm_pkg::BEST_DISTANCE_W'(exit_dist32);
    end
    res_idx = ncpm_pkg::BEST_INDEX_W'(tok_idx[MAX_CODES]);
  end

  assign out_free = !out_valid || results.ready;

  // output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || exit_valid;
      skid_valid <= 1'b0;
    end else if (exit_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // output register and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_dist <= skid_dist;
        out_idx  <= skid_idx;
      end else begin
        out_dist <= res_dist;
        out_idx  <= res_idx;
      end
    end else if (exit_valid) begin
      skid_dist <= res_dist;
      skid_idx  <= res_idx;
    end
  end

  assign results.valid         = out_valid;
  assign results.best_distance = out_dist;
  assign results.best_index    = out_idx;

  // checks
  `NCPM_ASSERT_IMPL(a_exit_while_busy, clk, rst, exit_valid, busy, "token left row while idle")
  `NCPM_ASSERT_NEXT(a_start_sets_busy, clk, rst, start, busy, "search start did not set busy")
  `NCPM_ASSERT_NEVER(a_skid_and_busy, clk, rst, skid_valid && busy, "skid full during a search")
  `NCPM_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid full, output empty")

endmodule

// ----- hw/rtl/ncpm_cell.sv -----
// one table entry: holds a code word and updates the passing search token
module ncpm_cell #(
  parameter int PIN_WIDTH = ncpm_pkg::PIN_WIDTH_DEF,
  parameter int DIST_W    = 5,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7,
  parameter int CELL_ID   = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load_en,
  input  logic [PIN_WIDTH-1:0]  load_code,
  input  logic [CNT_W-1:0]      count,
  input  ncpm_pkg::tok_ctl_t    in_ctl,
  input  logic [PIN_WIDTH-1:0]  in_sample,
  input  logic [DIST_W-1:0]     in_dist,
  input  logic [IDX_W-1:0]      in_idx,
  output ncpm_pkg::tok_ctl_t    out_ctl,
  output logic [PIN_WIDTH-1:0]  out_sample,
  output logic [DIST_W-1:0]     out_dist,
  output logic [IDX_W-1:0]      out_idx
);

  localparam logic [CNT_W-1:0] ID_CNT = CNT_W'(CELL_ID);
  localparam logic [IDX_W-1:0] ID_IDX = IDX_W'(CELL_ID);

  logic [PIN_WIDTH-1:0] code;
  logic [DIST_W-1:0]    code_dist;
  logic                 active;
  logic                 take;

  // stored code word, no reset
  always_ff @(posedge clk) begin
    if (load_en) begin
      code <= load_code;
    end
  end

  // distance to this entry and the strict-improvement test
  always_comb begin
    code_dist = DIST_W'($countones(in_sample ^ code));
    active    = ID_CNT < count;
    take      = in_ctl.valid && active && (!in_ctl.found || (code_dist < in_dist));
  end

  // token control to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
      out_ctl.found <= in_ctl.found || take;
    end
  end

  // token payload to the next cell
  always_ff @(posedge clk) begin
    out_sample <= in_sample;
    out_dist   <= take ? code_dist : in_dist;
    out_idx    <= take ? ID_IDX : in_idx;
  end

endmodule

// ----- tb/nearest_code_position_matcher_test.sv -----
module nearest_code_position_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODES         = ncpm_pkg::MAX_CODES_DEF;
  localparam int PIN_W         = ncpm_pkg::PIN_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 70;
  localparam int STALL_LIMIT   = 3000;

  // one input item as the predictor sees it
  typedef struct packed {
    logic [ncpm_pkg::KIND_W-1:0]        kind;
    logic [ncpm_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic [ncpm_pkg::ENTRY_CODE_W-1:0]  entry_code;
    logic [ncpm_pkg::PIN_SAMPLE_W-1:0]  pin_sample;
  } pin_item_t;

  // one decoded position
  typedef struct packed {
    logic [ncpm_pkg::BEST_DISTANCE_W-1:0] distance;
    logic [ncpm_pkg::BEST_INDEX_W-1:0]    index;
  } match_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ncpm_pkg::NUM_CODES_W-1:0] cfg_wdata;
  logic steady;

  ncpm_item_if   items ();
  ncpm_result_if results ();

  nearest_code_position_matcher dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [PIN_W-1:0]                 code_mirror [CODES];
  logic [PIN_W-1:0]                 seen_sample;
  logic [ncpm_pkg::NUM_CODES_W-1:0] search_count;
  match_t                           pending_matches[$];

  int mismatches;
  int items_sent;
  int loads_sent;
  int matches_checked;
  int settings_used;
  int quiet_cycles;

  // clock
  always #6 clk = ~clk;

  // result side backpressure
  always @(negedge clk) begin
    results.ready <= steady || ($urandom_range(99) >= 10);
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int active_span();
    return (search_count > CODES) ? CODES : int'(search_count);
  endfunction

  // track one accepted item and queue the position it should decode to
  task automatic track_item(input pin_item_t it);
    logic [PIN_W-1:0] word;
    match_t m;
    int span;
    int best;
    int d;
    if (it.kind == ncpm_pkg::KIND_LOAD) begin
      code_mirror[it.entry_index] = it.entry_code[PIN_W-1:0];
      return;
    end
    word = it.pin_sample[PIN_W-1:0];
    if (word == seen_sample) return;
    seen_sample = word;
    span = active_span();
    m.distance = ncpm_pkg::DIST_SAT;
    m.index = '0;
    best = 1000;
    for (int i = 0; i < span; i++) begin
      d = $countones(word ^ code_mirror[i]);
      if (d < best) begin
        best = d;
        m.index = ncpm_pkg::BEST_INDEX_W'(i);
      end
    end
    if (span != 0) begin
      m.distance = (best > 31) ? ncpm_pkg::DIST_SAT : ncpm_pkg::BEST_DISTANCE_W'(best);
    end
    pending_matches.push_back(m);
  endtask

  // drive one item, starting and ending at a falling edge
  task automatic send_item(input pin_item_t it);
    while (!steady && $urandom_range(99) < 10) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid       <= 1'b1;
    items.kind        <= it.kind;
    items.entry_index <= it.entry_index;
    items.entry_code  <= it.entry_code;
    items.pin_sample  <= it.pin_sample;
    do @(posedge clk); while (!items.ready);
    track_item(it);
    items_sent++;
    if (it.kind == ncpm_pkg::KIND_LOAD) loads_sent++;
    @(negedge clk);
  endtask

  task automatic load_entry(input logic [ncpm_pkg::ENTRY_INDEX_W-1:0] idx,
                            input logic [ncpm_pkg::ENTRY_CODE_W-1:0] code);
    pin_item_t it;
    it.kind        = ncpm_pkg::KIND_LOAD;
    it.entry_index = idx;
    it.entry_code  = code;
    it.pin_sample  = $urandom;
    send_item(it);
  endtask

  task automatic sample_pins(input logic [ncpm_pkg::PIN_SAMPLE_W-1:0] pins);
    pin_item_t it;
    it.kind        = ncpm_pkg::KIND_SAMPLE;
    it.entry_index = ncpm_pkg::ENTRY_INDEX_W'($urandom);
    it.entry_code  = ncpm_pkg::ENTRY_CODE_W'($urandom);
    it.pin_sample  = pins;
    send_item(it);
  endtask

  // stop sending until every queued position has come back
  task automatic hold_until_drained();
    items.valid <= 1'b0;
    do @(negedge clk); while (pending_matches.size() != 0);
  endtask

  // drained, then let any search or load still in flight finish
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_search_count(input logic [ncpm_pkg::NUM_CODES_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    search_count = value;
    settings_used++;
  endtask

  // a zero sample right after reset matches the cleared last sample
  task automatic test_reset_sample();
    sample_pins(32'h0000_0000);
    sample_pins(32'hFE00_0000);
  endtask

  // every table entry written once, extremes at both ends
  task automatic test_table_fill();
    for (int i = CODES - 1; i >= 0; i--) begin
      if (i == 0) load_entry(ncpm_pkg::ENTRY_INDEX_W'(i), '0);
      else if (i == CODES - 1) load_entry(ncpm_pkg::ENTRY_INDEX_W'(i), '1);
      else load_entry(ncpm_pkg::ENTRY_INDEX_W'(i), ncpm_pkg::ENTRY_CODE_W'($urandom));
    end
  endtask

  // reset count searches entries 0 to 49 only
  task automatic test_default_count();
    sample_pins({7'h7F, code_mirror[49] ^ 25'h000_0100});
    sample_pins({7'h00, code_mirror[50]});
    sample_pins({7'h55, code_mirror[3]});
  endtask

  // equal distances resolve to the lowest index
  task automatic test_ties();
    load_entry(6'd40, 25'h0F0_F0F0);
    load_entry(6'd7, 25'h0F0_F0F0);
    sample_pins(32'hA0F0_F0F0);
    sample_pins(32'h00F0_F0F1);
  endtask

  // masked-equal and repeated samples give nothing
  task automatic test_unchanged();
    sample_pins(32'h0123_4567);
    sample_pins(32'h0123_4567);
    sample_pins(32'hFF23_4567);
  endtask

  // count extremes, saturation above the table, widest distance
  task automatic test_count_extremes();
    set_search_count(7'd1);
    sample_pins(32'h01FF_FFFF);
    sample_pins(32'hFFFF_FFFF);
    set_search_count(7'd0);
    sample_pins(32'h0000_0001);
    set_search_count(7'd64);
    sample_pins(32'h01FF_FFFF);
    set_search_count(7'd127);
    sample_pins(32'h01FF_FFFE);
    set_search_count(7'd65);
    sample_pins(32'h0000_0000);
  endtask

  // mostly samples near stored codes, some repeats, loads and raw noise
  task automatic test_random_traffic();
    logic [ncpm_pkg::NUM_CODES_W-1:0] counts [8];
    logic [PIN_W-1:0] word;
    int pick;
    int span;
    counts = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd33, 7'd65, 7'd50, 7'd64};
    for (int ph = 0; ph < 8; ph++) begin
      set_search_count((ph == 7) ? ncpm_pkg::NUM_CODES_W'($urandom_range(127))
                                 : counts[ph]);
      steady = (ph == 2);
      for (int n = 0; n < 110; n++) begin
        if (n == 55) hold_until_drained();
        pick = $urandom_range(99);
        span = active_span();
        if (pick < 20) begin
          load_entry(ncpm_pkg::ENTRY_INDEX_W'($urandom_range(CODES - 1)),
                     ncpm_pkg::ENTRY_CODE_W'($urandom));
        end else if (pick < 70) begin
          word = code_mirror[$urandom_range((span == 0) ? CODES - 1 : span - 1)];
          repeat ($urandom_range(3)) word[$urandom_range(PIN_W - 1)] ^= 1'b1;
          sample_pins({7'($urandom), word});
        end else if (pick < 85) begin
          sample_pins({7'($urandom), seen_sample});
        end else begin
          sample_pins($urandom);
        end
      end
    end
    steady = 1'b0;
  endtask

  // compare each result item with the oldest queued position
  always @(posedge clk) begin : check_results
    match_t want;
    if (!rst && results.valid && results.ready) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected result distance %0d index %0d",
                                  results.best_distance, results.best_index));
      end else begin
        want = pending_matches.pop_front();
        if (results.best_distance !== want.distance)
          report_mismatch($sformatf("best_distance %0d, want %0d",
                                    results.best_distance, want.distance));
        if (results.best_index !== want.index)
          report_mismatch($sformatf("best_index %0d, want %0d",
                                    results.best_index, want.index));
        matches_checked++;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    steady            = 1'b0;
    items.valid       = 1'b0;
    items.kind        = ncpm_pkg::KIND_LOAD;
    items.entry_index = '0;
    items.entry_code  = '0;
    items.pin_sample  = '0;
    results.ready     = 1'b0;
    quiet_cycles      = 0;
    seen_sample       = '0;
    search_count      = ncpm_pkg::NUM_CODES_RESET;
    foreach (code_mirror[i]) code_mirror[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_sample();
    test_table_fill();
    test_default_count();
    test_ties();
    test_unchanged();
    test_count_extremes();
    test_random_traffic();
    settle();

    $display("sent %0d items (%0d table loads), checked %0d decoded positions",
             items_sent, loads_sent, matches_checked);
    $display("search count written %0d times, including 0, 1, 64 and values above the table",
             settings_used);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
